FILE: hw/rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_BYTES   = 16;
  localparam int unsigned KEY_IDX_W   = $clog2(KEY_BYTES);
  localparam int unsigned KEY_WORD_W  = 64;
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KSA_RD_N,
    ST_KSA_RD_ACC,
    ST_KSA_WR_ACC,
    ST_KSA_WR_N,
    ST_RD_I,
    ST_RD_J,
    ST_SWAP_J,
    ST_SWAP_I,
    ST_RESULT
  } rc4_state_t;

  // Permutation memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } rc4_ram_req_t;

endpackage

FILE: hw/rtl/rc4_in_if.sv
interface rc4_in_if;
  logic                          valid;
  logic                          ready;
  logic [rc4_pkg::BYTE_W-1:0]    data_byte;
  logic                          first_of_message;

  modport source (output valid, output data_byte, output first_of_message, input ready);
  modport sink   (input valid, input data_byte, input first_of_message, output ready);
endinterface

FILE: hw/rtl/rc4_out_if.sv
interface rc4_out_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

FILE: hw/rtl/rc4_cfg_if.sv
interface rc4_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rc4_pkg::CFG_IDX_W-1:0]  index;
  logic [rc4_pkg::KEY_WORD_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/rc4_sbox_ram.sv
// 256 x 8 permutation store: one write port, one registered read port
module rc4_sbox_ram (
  input  logic                       clk,
  input  rc4_pkg::rc4_ram_req_t      req,
  output logic [rc4_pkg::BYTE_W-1:0] rdata
);

  logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::TABLE_DEPTH];

  // Read returns the contents before a write at the same edge
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: hw/rtl/rc4_stream_cipher.sv
// RC4 stream cipher, one byte per beat.
// Each beat runs RD_I, RD_J, SWAP_J, SWAP_I, RESULT; a new byte is taken only back in IDLE.
// A first-of-message beat (or the first beat after reset) adds the key schedule: an identity
// fill of all 256 entries, then a mixing step per entry: read S[n], read S[acc], write both back swapped.
// The state sequence is set by the access pattern on the permutation RAM (one read, one write port).
// Reset clears indices, schedule flag and key words, key length to 16; RAM is undefined.
module rc4_stream_cipher (
  input  logic clk,
  input  logic rst,
  rc4_cfg_if.sink   cfg,
  rc4_in_if.sink    din,
  rc4_out_if.source dout
);

  rc4_pkg::rc4_state_t   state;
  rc4_pkg::rc4_state_t   state_next;
  rc4_pkg::rc4_ram_req_t ram_req;

  logic [rc4_pkg::BYTE_W-1:0]       rdata;
  logic [rc4_pkg::KEY_WORD_W-1:0]   key_low;
  logic [rc4_pkg::KEY_WORD_W-1:0]   key_high;
  logic [2*rc4_pkg::KEY_WORD_W-1:0] key_all;
  logic [rc4_pkg::KEY_LEN_W-1:0]    key_len;
  logic [rc4_pkg::KEY_IDX_W-1:0]    key_last;
  logic [rc4_pkg::KEY_IDX_W-1:0]    kidx;
  logic [rc4_pkg::BYTE_W-1:0]       key_byte;

  logic [rc4_pkg::BYTE_W-1:0] data_reg;
  logic [rc4_pkg::ADDR_W-1:0] idx_i;
  logic [rc4_pkg::ADDR_W-1:0] idx_j;
  logic [rc4_pkg::ADDR_W-1:0] idx_i_inc;
  logic [rc4_pkg::ADDR_W-1:0] idx_t;
  logic [rc4_pkg::ADDR_W-1:0] n;
  logic [rc4_pkg::ADDR_W-1:0] acc;
  logic [rc4_pkg::ADDR_W-1:0] acc_sum;
  logic [rc4_pkg::BYTE_W-1:0] si;
  logic [rc4_pkg::BYTE_W-1:0] sj;
  logic [rc4_pkg::BYTE_W-1:0] keystream;
  logic                       sched_done;
  logic                       fwd_i;
  logic                       out_valid;
  logic [rc4_pkg::BYTE_W-1:0] out_byte;
  logic                       out_free;
  logic                       last_n;

  rc4_sbox_ram u_sbox (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Configuration registers, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rc4_pkg::REG_KEY_LOW:  key_low  <= cfg.data;
        rc4_pkg::REG_KEY_HIGH: key_high <= cfg.data;
        rc4_pkg::REG_KEY_LEN:  key_len  <= cfg.data[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Last used key byte index: length 0 acts as 1, above 16 saturates
  always_comb begin
    if (key_len == '0) begin
      key_last = '0;
    end else if (key_len > rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_BYTES)) begin
      key_last = rc4_pkg::KEY_IDX_W'(rc4_pkg::KEY_BYTES - 1);
    end else begin
      key_last = rc4_pkg::KEY_IDX_W'(key_len - 5'd1);
    end
  end

  assign key_all   = {key_high, key_low};
  assign key_byte  = key_all[{kidx, 3'b000} +: rc4_pkg::BYTE_W];
  assign idx_i_inc = idx_i + 8'd1;
  assign acc_sum   = acc + rdata + key_byte;
  assign idx_t     = si + sj;
  assign keystream = fwd_i ? sj : rdata;
  assign out_free  = !out_valid || dout.ready;
  assign last_n    = (n == rc4_pkg::ADDR_W'(rc4_pkg::TABLE_DEPTH - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        if (din.valid) begin
          state_next = (din.first_of_message || !sched_done) ? rc4_pkg::ST_INIT
                                                             : rc4_pkg::ST_RD_I;
        end
      end
      rc4_pkg::ST_INIT: begin
        if (last_n) begin
          state_next = rc4_pkg::ST_KSA_RD_N;
        end
      end
      rc4_pkg::ST_KSA_RD_N:   state_next = rc4_pkg::ST_KSA_RD_ACC;
      rc4_pkg::ST_KSA_RD_ACC: state_next = rc4_pkg::ST_KSA_WR_ACC;
      rc4_pkg::ST_KSA_WR_ACC: state_next = rc4_pkg::ST_KSA_WR_N;
      rc4_pkg::ST_KSA_WR_N: begin
        state_next = last_n ? rc4_pkg::ST_RD_I : rc4_pkg::ST_KSA_RD_N;
      end
      rc4_pkg::ST_RD_I:   state_next = rc4_pkg::ST_RD_J;
      rc4_pkg::ST_RD_J:   state_next = rc4_pkg::ST_SWAP_J;
      rc4_pkg::ST_SWAP_J: state_next = rc4_pkg::ST_SWAP_I;
      rc4_pkg::ST_SWAP_I: state_next = rc4_pkg::ST_RESULT;
      rc4_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      default: state_next = rc4_pkg::ST_IDLE;
    endcase
  end

  // RAM port and handshake outputs
  always_comb begin
    ram_req   = '0;
    din.ready = 1'b0;
    unique case (state)
      rc4_pkg::ST_IDLE: din.ready = 1'b1;
      rc4_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = n;
        ram_req.wdata = n;
      end
      rc4_pkg::ST_KSA_RD_N: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = n;
      end
      rc4_pkg::ST_KSA_RD_ACC: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = acc_sum;
      end
      rc4_pkg::ST_KSA_WR_ACC: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = acc;
        ram_req.wdata = si;
      end
      rc4_pkg::ST_KSA_WR_N: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = n;
        ram_req.wdata = sj;
      end
      rc4_pkg::ST_RD_I: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_i_inc;
      end
      rc4_pkg::ST_RD_J: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_j + rdata;
      end
      rc4_pkg::ST_SWAP_J: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_j;
        ram_req.wdata = si;
      end
      rc4_pkg::ST_SWAP_I: begin
        // S[i] is written at this edge, so a read of it is forwarded
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_i;
        ram_req.wdata = sj;
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_t;
      end
      rc4_pkg::ST_RESULT: ;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rc4_pkg::ST_IDLE;
      sched_done <= 1'b0;
      idx_i      <= '0;
      idx_j      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rc4_pkg::ST_KSA_WR_N && last_n) begin
        sched_done <= 1'b1;
        idx_i      <= '0;
        idx_j      <= '0;
      end
      if (state == rc4_pkg::ST_RD_I) begin
        idx_i <= idx_i_inc;
      end
      if (state == rc4_pkg::ST_RD_J) begin
        idx_j <= idx_j + rdata;
      end
      if (state == rc4_pkg::ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        data_reg <= din.data_byte;
        n        <= '0;
        acc      <= '0;
        kidx     <= '0;
      end
      rc4_pkg::ST_INIT: n <= n + 8'd1;
      rc4_pkg::ST_KSA_RD_ACC: begin
        si  <= rdata;
        acc <= acc_sum;
      end
      rc4_pkg::ST_KSA_WR_ACC: sj <= rdata;
      rc4_pkg::ST_KSA_WR_N: begin
        n    <= n + 8'd1;
        kidx <= (kidx == key_last) ? '0 : kidx + 4'd1;
      end
      rc4_pkg::ST_RD_J:   si <= rdata;
      rc4_pkg::ST_SWAP_J: sj <= rdata;
      rc4_pkg::ST_SWAP_I: fwd_i <= (idx_t == idx_i);
      rc4_pkg::ST_RESULT: begin
        if (out_free) begin
          out_byte <= data_reg ^ keystream;
        end
      end
      default: ;
    endcase
  end

  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;

endmodule

FILE: tb/sv/rc4_stream_cipher_test.sv
module rc4_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;  // well above a full key schedule
  localparam int unsigned SETTLE_CYCLES = 8;    // longer than a beat's pass through the cipher
  localparam int unsigned RANDOM_BEATS = 360;
  localparam int unsigned CALM_FROM = 310;      // no idling on either side past this

  typedef logic [rc4_pkg::BYTE_W-1:0]     byte_t;
  typedef logic [rc4_pkg::KEY_WORD_W-1:0] key_word_t;
  typedef logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_t;

  typedef enum logic {ROW_BEAT, ROW_KEY} row_kind_t;

  // One stimulus row: a data beat, or a key update done while the cipher is idle
  typedef struct {
    row_kind_t kind;
    byte_t     data;
    logic      first;
    logic      known;    // want holds a published vector byte
    byte_t     want;
    logic [2:0] regs;    // bit n selects register index n
    key_word_t lo;
    key_word_t hi;
    key_len_t  len;
  } plan_row_t;

  logic clk;
  logic rst;

  rc4_cfg_if cfg ();
  rc4_in_if  din ();
  rc4_out_if dout ();

  rc4_stream_cipher u_dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .din  (din),
    .dout (dout)
  );

  // Cipher state mirror
  key_word_t key_lo = '0;
  key_word_t key_hi = '0;
  key_len_t  key_len = rc4_pkg::KEY_LEN_RESET;
  byte_t     perm [rc4_pkg::TABLE_DEPTH];
  byte_t     ks_i = '0;
  byte_t     ks_j = '0;
  logic      sched_ok = 1'b0;

  byte_t     cipher_q [$];
  byte_t     pred_byte;
  byte_t     exp_byte;
  byte_t     got_byte;
  plan_row_t plan [$];

  // Side-band copy of a published vector byte, launched with its beat
  logic  known_on = 1'b0;
  byte_t known_byte = '0;

  bit calm = 1'b0;
  bit src_busy = 1'b1;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_sched = 0;
  int unsigned n_reg = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // KSA: identity fill, then cyclic key mixing
  function automatic void run_key_schedule();
    int unsigned klen;
    int unsigned kn;
    key_word_t   w;
    byte_t       acc;
    byte_t       kb;
    byte_t       tmp;
    klen = 32'(key_len);
    if (klen == 0) klen = 1;
    if (klen > rc4_pkg::KEY_BYTES) klen = rc4_pkg::KEY_BYTES;
    acc = '0;
    for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) perm[n] = byte_t'(n);
    for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) begin
      kn = n % klen;
      w = (kn < 8) ? key_lo : key_hi;
      kb = w[(kn % 8) * 8 +: 8];
      acc = acc + perm[n] + kb;
      tmp = perm[acc];
      perm[acc] = perm[n];
      perm[n] = tmp;
    end
    ks_i = '0;
    ks_j = '0;
    sched_ok = 1'b1;
    n_sched++;
  endfunction

  // PRGA step, data XOR keystream; a first beat, or any beat before a schedule, runs KSA first
  function automatic byte_t cipher_byte(input byte_t d, input logic first);
    byte_t si;
    byte_t sj;
    byte_t t;
    if (first || !sched_ok) run_key_schedule();
    ks_i = ks_i + 1'b1;
    ks_j = ks_j + perm[ks_i];
    si = perm[ks_i];
    sj = perm[ks_j];
    perm[ks_i] = sj;
    perm[ks_j] = si;
    t = si + sj;
    return d ^ perm[t];
  endfunction

  function automatic void add_beat(input byte_t d, input logic f, input logic known,
                                   input byte_t want);
    plan_row_t r;
    r = '{kind: ROW_BEAT, data: d, first: f, known: known, want: want,
          regs: '0, lo: '0, hi: '0, len: '0};
    plan.push_back(r);
  endfunction

  function automatic void add_key(input logic [2:0] regs, input key_word_t lo,
                                  input key_word_t hi, input key_len_t len);
    plan_row_t r;
    r = '{kind: ROW_KEY, data: '0, first: 1'b0, known: 1'b0, want: '0,
          regs: regs, lo: lo, hi: hi, len: len};
    plan.push_back(r);
  endfunction

  // Published vector, first byte in the top bits; first beat restarts the key
  function automatic void add_vector(input logic [127:0] pt, input logic [127:0] ct,
                                     input int unsigned nbytes);
    for (int k = 0; k < nbytes; k++)
      add_beat(pt[(nbytes - 1 - k) * 8 +: 8], k == 0, 1'b1, ct[(nbytes - 1 - k) * 8 +: 8]);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input monitor: advance the mirror on each accepted beat
  always @(posedge clk) begin
    if (!rst && din.valid && din.ready) begin
      pred_byte = cipher_byte(din.data_byte, din.first_of_message);
      cipher_q.push_back(known_on ? known_byte : pred_byte);
    end
  end

  // Register writes land in the mirror's key copy
  always @(posedge clk) begin
    if (!rst && cfg.valid && cfg.ready) begin
      n_reg++;
      case (cfg.index)
        rc4_pkg::REG_KEY_LOW:  key_lo = cfg.data;
        rc4_pkg::REG_KEY_HIGH: key_hi = cfg.data;
        rc4_pkg::REG_KEY_LEN:  key_len = cfg.data[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Output checker
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) begin
      got_byte = dout.out_byte;
      if (cipher_q.size() == 0) begin
        $error("out_byte: expected no beat, got 0x%02h", got_byte);
        fail_count++;
      end else begin
        exp_byte = cipher_q.pop_front();
        n_checked++;
        if (got_byte !== exp_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", exp_byte, got_byte);
          fail_count++;
        end
      end
    end
  end

  // Output backpressure: stall bursts, with busy and quiet stretches
  initial begin
    int unsigned hold;
    int unsigned mode_left;
    bit          sink_busy;
    hold = 0;
    mode_left = 0;
    sink_busy = 1'b0;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        sink_busy = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold > 0) hold--;
      else if (!calm && sink_busy && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 16);
      dout.ready <= (hold == 0);
    end
  end

  // Watchdog: ends the run when no beat moves for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((din.valid && din.ready) || (dout.valid && dout.ready) || (cfg.valid && cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Data beat with an optional idle gap ahead of it; valid stays up between beats
  task automatic send_beat(input byte_t d, input logic f, input logic known, input byte_t want);
    if (!calm && src_busy && $urandom_range(0, 3) == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.data_byte <= d;
    din.first_of_message <= f;
    known_on <= known;
    known_byte <= want;
    do @(posedge clk); while (!din.ready);
    n_sent++;
  endtask

  // Hold off input until every result is back and the pipe has settled
  task automatic drain();
    din.valid <= 1'b0;
    do @(posedge clk); while (cipher_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes, back to back, in index order
  task automatic program_key(input logic [2:0] regs, input key_word_t lo, input key_word_t hi,
                             input key_len_t len);
    logic [rc4_pkg::CFG_IDX_W-1:0] r;
    for (int k = 0; k < 3; k++) begin
      if (regs[k]) begin
        r = rc4_pkg::CFG_IDX_W'(k);
        cfg.valid <= 1'b1;
        cfg.index <= r;
        if (r == rc4_pkg::REG_KEY_LOW) cfg.data <= lo;
        else if (r == rc4_pkg::REG_KEY_HIGH) cfg.data <= hi;
        else cfg.data <= rc4_pkg::KEY_WORD_W'(len);
        do @(posedge clk); while (!cfg.ready);
      end
    end
    cfg.valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int unsigned msg_len;
    logic        msg_first;
    logic [2:0]  regs;
    key_word_t   lo;
    key_word_t   hi;
    key_len_t    len;
    bit          rekey;

    rst <= 1'b1;
    cfg.valid <= 1'b0;
    cfg.index <= rc4_pkg::REG_KEY_LOW;
    cfg.data <= '0;
    din.valid <= 1'b0;
    din.data_byte <= '0;
    din.first_of_message <= 1'b0;

    // Directed: all-zero key from reset, beats before any message start
    add_beat(8'h00, 1'b0, 1'b1, 8'hde);
    add_beat(8'h00, 1'b0, 1'b1, 8'h18);
    add_beat(8'hff, 1'b0, 1'b1, 8'h76);
    add_beat(8'h00, 1'b0, 1'b1, 8'h41);
    // restart on the same key
    add_beat(8'hff, 1'b1, 1'b1, 8'h21);
    // 8-byte key, byte order check
    add_key(3'b101, 64'hefcd_ab89_6745_2301, '0, 5'd8);
    add_vector(128'h0123_4567_89ab_cdef, 128'h75b7_8780_99e0_c596, 8);
    // 3-byte ASCII key
    add_key(3'b101, 64'h0000_0000_0079_654b, '0, 5'd3);
    add_vector(128'h50_6c61_696e_7465_7874, 128'hbb_f316_e8d9_40af_0ad3, 9);
    // key change mid-message is not seen until the next restart
    add_key(3'b011, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0001, '0);
    add_beat(8'h3c, 1'b0, 1'b0, '0);
    // zero length reads as one byte
    add_key(3'b100, '0, '0, 5'd0);
    add_beat(8'h81, 1'b1, 1'b0, '0);
    // length past 16 saturates
    add_key(3'b100, '0, '0, 5'd31);
    add_beat(8'h7e, 1'b1, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_KEY) begin
        drain();
        program_key(plan[r].regs, plan[r].lo, plan[r].hi, plan[r].len);
      end else begin
        send_beat(plan[r].data, plan[r].first, plan[r].known, plan[r].want);
      end
    end

    // Random messages, rekeying between some of them
    rekey = 1'b1;
    while (n_sent < plan.size() + RANDOM_BEATS) begin
      if (rekey && !calm) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) lo = '1;
        if ($urandom_range(0, 7) == 0) hi = '0;
        case ($urandom_range(0, 5))
          0: len = 5'd0;
          1: len = 5'd1;
          2: len = 5'd16;
          3: len = key_len_t'($urandom_range(17, 31));
          default: len = key_len_t'($urandom_range(1, 16));
        endcase
        regs = ($urandom_range(0, 2) == 0) ? 3'(($urandom_range(1, 7))) : 3'b111;
        drain();
        program_key(regs, lo, hi, len);
      end
      calm = (n_sent >= plan.size() + CALM_FROM);
      src_busy = $urandom_range(0, 2) != 0;
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      msg_first = $urandom_range(0, 5) != 0;
      for (int k = 0; k < msg_len; k++)
        send_beat(byte_t'($urandom_range(0, 255)),
                  (k == 0) ? msg_first : ($urandom_range(0, 30) == 0), 1'b0, '0);
      rekey = $urandom_range(0, 2) == 0;
    end

    drain();
    $display("%0d bytes ciphered, %0d results checked", n_sent, n_checked);
    $display("%0d key schedules over %0d register writes", n_sched, n_reg);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
